// File: hdl/bgdc_pkg.sv
// Shared types, codes and the seven-segment table for the button gesture digit counter.
// No dependencies; every other file in hdl/ imports this package.
package bgdc_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int TICK_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int SEG_W      = 7;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_LONG_HOLD  = 2'd0;
  localparam logic [1:0] REG_DOUBLE_GAP = 2'd1;
  localparam logic [1:0] REG_REPEAT     = 2'd2;

  localparam logic [TICK_W-1:0]  LONG_HOLD_RST  = 8'd31;
  localparam logic [TICK_W-1:0]  DOUBLE_GAP_RST = 8'd14;
  localparam logic [TICK_W-1:0]  REPEAT_RST     = 8'd20;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX      = 4'd9;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HOLD    = 3'd1,
    PH_GAP     = 3'd2,
    PH_CONFIRM = 3'd3,
    PH_LOCK    = 3'd4,
    PH_REPEAT  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_INC  = 2'd1,
    EV_DEC  = 2'd2
  } event_t;

  typedef struct packed {
    logic [TICK_W-1:0] long_hold_ticks;
    logic [TICK_W-1:0] double_gap_ticks;
    logic [TICK_W-1:0] repeat_ticks;
  } cfg_t;

  function automatic logic [DIGIT_W-1:0] digit_up(input logic [DIGIT_W-1:0] d);
    digit_up = (d >= DIGIT_MAX) ? '0 : DIGIT_W'(d + 1'b1);
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_down(input logic [DIGIT_W-1:0] d);
    digit_down = (d == '0 || d > DIGIT_MAX) ? DIGIT_MAX : DIGIT_W'(d - 1'b1);
  endfunction

  // common cathode, bit0 = a .. bit6 = g; blank for codes above nine
  function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    seg_code = s;
  endfunction

endpackage

// File: hdl/button_gesture_digit_counter.sv
// Top level of the button gesture digit counter: stream ports, input register,
// result register and the APB register file. Depends on bgdc_pkg, bgdc_cfg, bgdc_step.
//
//  channel   | dir | transaction          | payload
//  ----------+-----+----------------------+------------------------------------
//  s_axis    | in  | one button sample    | tdata[0] button_level (0 = pressed)
//  m_axis    | out | one result per tick  | tdata digit, segments, event
//  apb       | in  | register read/write  | 3 x 8-bit limits at 0x0, 0x4, 0x8
//
// Two register stages: a sample is taken into the input register; when it
// moves on, the state machine steps and the result register loads, so m_tvalid
// rises as the sample enters the result register. One sample per cycle is
// sustained while m_tready stays high. A stall on m_axis holds the result
// register; an empty input register still takes one more sample, and once it
// holds one and the result register is full, s_tready follows m_tready in the
// same cycle. Reset is synchronous: phase idle, counter and digit zero, limits
// at 31, 14 and 20 ticks, both stages empty.
module button_gesture_digit_counter
  import bgdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // stream in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [0] button_level, [7:1] zero
  // stream out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // [3:0] digit_value, [10:4] segment_bits,
                                           // [12:11] event_kind, [15:13] zero
  // APB
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t               cfg;
  logic               in_valid;
  logic               in_level;
  logic               advance;     // result register may load this cycle
  logic               step_en;
  logic [DIGIT_W-1:0] digit_next;
  event_t             event_next;
  logic [DIGIT_W-1:0] out_digit;
  logic [SEG_W-1:0]   out_seg;
  event_t             out_event;

  bgdc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = !m_tvalid || m_tready;
  assign step_en  = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_level <= s_tdata[0];
    end
  end

  bgdc_step u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step_en    (step_en),
    .pressed    (!in_level),
    .digit_next (digit_next),
    .event_next (event_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_digit <= digit_next;
      out_seg   <= seg_code(digit_next);
      out_event <= event_next;
    end
  end

  assign m_tdata = {3'b000, out_event, out_seg, out_digit};

endmodule

// File: hdl/bgdc_cfg.sv
// APB register file: long hold, double gap and repeat tick limits.
// Depends on bgdc_pkg.
module bgdc_cfg
  import bgdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_hold_ticks  <= LONG_HOLD_RST;
      cfg.double_gap_ticks <= DOUBLE_GAP_RST;
      cfg.repeat_ticks     <= REPEAT_RST;
    end else if (wr) begin
      unique case (idx)
        REG_LONG_HOLD:  cfg.long_hold_ticks  <= pwdata[TICK_W-1:0];
        REG_DOUBLE_GAP: cfg.double_gap_ticks <= pwdata[TICK_W-1:0];
        REG_REPEAT:     cfg.repeat_ticks     <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LONG_HOLD:  prdata = CFG_DATA_W'(cfg.long_hold_ticks);
      REG_DOUBLE_GAP: prdata = CFG_DATA_W'(cfg.double_gap_ticks);
      REG_REPEAT:     prdata = CFG_DATA_W'(cfg.repeat_ticks);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: hdl/bgdc_step.sv
// Gesture state machine: phase, tick counter and digit, one step per sample.
// Depends on bgdc_pkg.
module bgdc_step
  import bgdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               step_en,
  input  logic               pressed,
  output logic [DIGIT_W-1:0] digit_next,
  output event_t             event_next
);

  phase_t              phase, phase_next;
  logic [TICK_W-1:0]   tick_count, tick_count_next;
  logic [DIGIT_W-1:0]  digit;
  logic [TICK_W-1:0]   cnt_inc;
  logic [TICK_W:0]     cnt_plus1;
  logic [TICK_W:0]     lock_plus1;
  logic                hold_long, gap_end, repeat_hit, lock_end, no_lock;

  assign cnt_inc    = TICK_W'(tick_count + 1'b1);
  assign cnt_plus1  = {1'b0, tick_count} + 1'b1;
  assign lock_plus1 = {1'b0, cnt_inc} + 1'b1;
  assign hold_long  = tick_count >= cfg.long_hold_ticks;
  assign gap_end    = tick_count >= cfg.double_gap_ticks;
  assign repeat_hit = cnt_plus1 >= {1'b0, cfg.repeat_ticks};
  assign lock_end   = lock_plus1 >= {1'b0, cfg.repeat_ticks};
  assign no_lock    = cfg.repeat_ticks < TICK_W'(2);

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HOLD: begin
        if (!pressed)       phase_next = PH_GAP;
        else if (hold_long) phase_next = PH_REPEAT;
      end
      PH_GAP: begin
        if (gap_end)      phase_next = pressed ? PH_HOLD : PH_IDLE;
        else if (pressed) phase_next = PH_CONFIRM;
      end
      PH_CONFIRM: begin
        if (pressed) phase_next = no_lock ? PH_IDLE : PH_LOCK;
        else         phase_next = PH_IDLE;
      end
      PH_LOCK: begin
        if (lock_end) phase_next = PH_IDLE;
      end
      PH_REPEAT: begin
        if (!pressed) phase_next = PH_IDLE;
      end
      default: phase_next = pressed ? PH_HOLD : PH_IDLE;
    endcase
  end

  // counter, digit and event
  always_comb begin
    tick_count_next = tick_count;
    digit_next      = digit;
    event_next      = EV_NONE;
    unique case (phase)
      PH_HOLD: begin
        if (!pressed) begin
          tick_count_next = '0;
        end else if (hold_long) begin
          digit_next      = digit_up(digit);
          event_next      = EV_INC;
          tick_count_next = '0;
        end else begin
          tick_count_next = cnt_inc;
        end
      end
      PH_GAP: begin
        if (gap_end) begin
          digit_next      = digit_up(digit);
          event_next      = EV_INC;
          tick_count_next = '0;
        end else if (pressed) begin
          tick_count_next = '0;
        end else begin
          tick_count_next = cnt_inc;
        end
      end
      PH_CONFIRM: begin
        tick_count_next = '0;
        if (pressed) begin
          digit_next = digit_down(digit);
          event_next = EV_DEC;
        end
      end
      PH_LOCK: begin
        tick_count_next = lock_end ? '0 : cnt_inc;
      end
      PH_REPEAT: begin
        if (!pressed) begin
          tick_count_next = '0;
        end else if (repeat_hit) begin
          digit_next      = digit_up(digit);
          event_next      = EV_INC;
          tick_count_next = '0;
        end else begin
          tick_count_next = cnt_inc;
        end
      end
      default: tick_count_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      digit      <= '0;
    end else if (step_en) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      digit      <= digit_next;
    end
  end

endmodule
